### hdl/rbst_pkg.sv
// Shared constants and types for the ray versus box slab test pipeline.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package rbst_pkg;

  // Default coordinate width and the fixed width of every field on the ports.
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FieldWidth    = 32;
  localparam int unsigned NumAxes       = 3;
  localparam int unsigned NumFields     = 2 * NumAxes;
  localparam int unsigned CfgAddrWidth  = 3;
  localparam int unsigned OutDataWidth  = 8;

  // Configuration register indexes.
  typedef enum logic [CfgAddrWidth-1:0] {
    RegOriginX  = 3'd0,
    RegOriginY  = 3'd1,
    RegOriginZ  = 3'd2,
    RegThroughX = 3'd3,
    RegThroughY = 3'd4,
    RegThroughZ = 3'd5
  } cfg_reg_e;

  // Ordered axis pairs (near axis, far axis) with distinct axes. The far
  // value of one axis must reach the near value of every other axis.
  localparam int unsigned NumPairs = NumAxes * (NumAxes - 1);
  localparam int unsigned PairNear [NumPairs] = '{0, 0, 1, 1, 2, 2};
  localparam int unsigned PairFar  [NumPairs] = '{1, 2, 0, 2, 0, 1};

  // Per-axis status carried down the pipeline.
  typedef struct packed {
    logic [NumAxes-1:0] dir_zero;  // ray direction is zero on this axis
    logic [NumAxes-1:0] axis_ok;   // single-axis checks passed
  } axis_flags_t;

endpackage

### hdl/ray_box_slab_test.sv
// Top level of the exact ray versus axis-aligned box slab test.
// Depends on rbst_pkg, rbst_prep, rbst_mul and rbst_cmp.
//
// Channel   Direction  Signals                         Payload
// s_axis    in         tvalid, tready, tdata[191:0]    one box (six 32-bit coordinates)
// m_axis    out        tvalid, tready, tdata[7:0]      hit flag in bit 0
// cfg       in         cfg_we, cfg_addr[2:0], cfg_wdata  ray origin and second point
//
// A box enters whenever s_axis_tready is high, one per cycle sustained. Its result
// is registered in each stage in turn before it can leave on m_axis: one stage
// forms slab distances, one holds the twelve cross products, one compares and
// registers the hit flag. Each stage has its own valid bit, so an output stall
// fills empty stages first and loses or repeats no transaction. Reset clears
// the valid bits and the ray registers (a zero-length ray at the origin).
//
// The ray is origin O and direction D = T - O, with T the second point. On each
// axis the near and far slab distances are fractions num/|D|. The ray meets the
// box when every far value is at least every near value and at least zero, each
// axis alone is consistent, and axes with a zero direction contain the origin.
// Fractions are compared exactly by cross multiplication, so nothing rounds.
module ray_box_slab_test #(
  parameter int unsigned COORD_WIDTH = rbst_pkg::CoordWidthDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Box transactions.
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // Fields from bit 0 up: box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y,
  // box_hi_z, 32 bits each.
  input  logic [rbst_pkg::NumFields*rbst_pkg::FieldWidth-1:0] s_axis_tdata,
  // Result transactions.
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // Fields from bit 0 up: hit (1 bit), then seven zero bits.
  output logic [rbst_pkg::OutDataWidth-1:0]          m_axis_tdata,
  // Configuration write port.
  input  logic                                       cfg_we_i,
  input  logic [rbst_pkg::CfgAddrWidth-1:0]          cfg_addr_i,
  input  logic [rbst_pkg::FieldWidth-1:0]            cfg_wdata_i
);

  localparam int unsigned NumAxes   = rbst_pkg::NumAxes;
  localparam int unsigned NumPairs  = rbst_pkg::NumPairs;
  localparam int unsigned FieldW    = rbst_pkg::FieldWidth;
  localparam int unsigned ProdWidth = 2 * COORD_WIDTH + 2;

  // Ray registers, low COORD_WIDTH bits of each written word.
  logic [NumAxes-1:0][COORD_WIDTH-1:0] origin_q, through_q;

  logic [NumAxes-1:0][COORD_WIDTH-1:0] box_lo, box_hi;

  logic                                prep_valid, prep_ready;
  logic [NumAxes-1:0][COORD_WIDTH:0]   prep_near, prep_far;
  logic [NumAxes-1:0][COORD_WIDTH-1:0] prep_den;
  rbst_pkg::axis_flags_t               prep_flags;

  logic                                mul_valid, mul_ready;
  logic [NumPairs-1:0][ProdWidth-1:0]  mul_far_prod, mul_near_prod;
  rbst_pkg::axis_flags_t               mul_flags;

  logic                                hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q  <= '0;
      through_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rbst_pkg::cfg_reg_e'(cfg_addr_i))
        rbst_pkg::RegOriginX:  origin_q[0]  <= cfg_wdata_i[COORD_WIDTH-1:0];
        rbst_pkg::RegOriginY:  origin_q[1]  <= cfg_wdata_i[COORD_WIDTH-1:0];
        rbst_pkg::RegOriginZ:  origin_q[2]  <= cfg_wdata_i[COORD_WIDTH-1:0];
        rbst_pkg::RegThroughX: through_q[0] <= cfg_wdata_i[COORD_WIDTH-1:0];
        rbst_pkg::RegThroughY: through_q[1] <= cfg_wdata_i[COORD_WIDTH-1:0];
        rbst_pkg::RegThroughZ: through_q[2] <= cfg_wdata_i[COORD_WIDTH-1:0];
        default: ;  // indexes past the last register are ignored
      endcase
    end
  end

  // Only the low COORD_WIDTH bits of each 32-bit field take part.
  for (genvar a = 0; a < NumAxes; a++) begin : g_unpack
    assign box_lo[a] = s_axis_tdata[a*FieldW +: COORD_WIDTH];
    assign box_hi[a] = s_axis_tdata[(a+NumAxes)*FieldW +: COORD_WIDTH];
  end

  rbst_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .box_lo_i  (box_lo),
    .box_hi_i  (box_hi),
    .origin_i  (origin_q),
    .through_i (through_q),
    .valid_o   (prep_valid),
    .ready_i   (prep_ready),
    .near_o    (prep_near),
    .far_o     (prep_far),
    .den_o     (prep_den),
    .flags_o   (prep_flags)
  );

  rbst_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (prep_valid),
    .ready_o     (prep_ready),
    .near_i      (prep_near),
    .far_i       (prep_far),
    .den_i       (prep_den),
    .flags_i     (prep_flags),
    .valid_o     (mul_valid),
    .ready_i     (mul_ready),
    .far_prod_o  (mul_far_prod),
    .near_prod_o (mul_near_prod),
    .flags_o     (mul_flags)
  );

  rbst_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mul_valid),
    .ready_o     (mul_ready),
    .far_prod_i  (mul_far_prod),
    .near_prod_i (mul_near_prod),
    .flags_i     (mul_flags),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .hit_o       (hit)
  );

  assign m_axis_tdata = {{(rbst_pkg::OutDataWidth-1){1'b0}}, hit};

`ifndef SYNTHESIS
  // Backpressure reaches the input only when every stage holds a transaction
  // and the output is stalled.
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (prep_valid && mul_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while a pipeline stage is free");

  // A nonzero direction always yields a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_valid |-> ((prep_flags.dir_zero[0] || prep_den[0] != '0) &&
                    (prep_flags.dir_zero[1] || prep_den[1] != '0) &&
                    (prep_flags.dir_zero[2] || prep_den[2] != '0)))
    else $error("zero denominator on an axis with nonzero direction");

  // A result can only appear once the multiply stage held a transaction.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(mul_valid))
    else $error("result appeared without a transaction in the multiply stage");
`endif

endmodule

### hdl/rbst_prep.sv
// First pipeline stage: direction, slab distances and per-axis checks.
// Depends on rbst_pkg.
module rbst_prep #(
  parameter int unsigned COORD_WIDTH = rbst_pkg::CoordWidthDef
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0]    box_lo_i,
  input  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0]    box_hi_i,
  input  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0]    origin_i,
  input  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0]    through_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH:0]      near_o,
  output logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH:0]      far_o,
  output logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0]    den_o,
  output rbst_pkg::axis_flags_t                            flags_o
);

  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH:0]   near_d, far_d;
  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0] den_d;
  rbst_pkg::axis_flags_t                         flags_d;
  logic                                          valid_q;
  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH:0]   near_q, far_q;
  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0] den_q;
  rbst_pkg::axis_flags_t                         flags_q;

  for (genvar a = 0; a < rbst_pkg::NumAxes; a++) begin : g_axis
    logic signed [COORD_WIDTH:0] org, thr, lo, hi;
    logic signed [COORD_WIDTH:0] dir, dir_mag;
    logic                        dir_neg;

    assign org = {origin_i[a][COORD_WIDTH-1], origin_i[a]};
    assign thr = {through_i[a][COORD_WIDTH-1], through_i[a]};
    assign lo  = {box_lo_i[a][COORD_WIDTH-1], box_lo_i[a]};
    assign hi  = {box_hi_i[a][COORD_WIDTH-1], box_hi_i[a]};

    // The difference of two coordinates always fits one extra bit.
    assign dir     = thr - org;
    assign dir_neg = dir[COORD_WIDTH];
    assign dir_mag = dir_neg ? -dir : dir;

    // A negative direction swaps the slab planes and flips the numerators.
    assign near_d[a] = dir_neg ? (org - hi) : (lo - org);
    assign far_d[a]  = dir_neg ? (org - lo) : (hi - org);
    assign den_d[a]  = dir_mag[COORD_WIDTH-1:0];

    assign flags_d.dir_zero[a] = (dir == '0);
    // With a zero direction the origin must sit inside the slab. Otherwise the
    // box must not be inverted and the far plane must not lie behind the origin.
    assign flags_d.axis_ok[a]  = (dir == '0) ? ((lo <= org) && (org <= hi))
                                            : ((lo <= hi) && !far_d[a][COORD_WIDTH]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      near_q  <= near_d;
      far_q   <= far_d;
      den_q   <= den_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign near_o  = near_q;
  assign far_o   = far_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

### hdl/rbst_mul.sv
// Second pipeline stage: cross products of slab distances and denominators.
// Depends on rbst_pkg.
module rbst_mul #(
  parameter int unsigned COORD_WIDTH = rbst_pkg::CoordWidthDef
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  output logic                                              ready_o,
  input  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH:0]       near_i,
  input  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH:0]       far_i,
  input  logic [rbst_pkg::NumAxes-1:0][COORD_WIDTH-1:0]     den_i,
  input  rbst_pkg::axis_flags_t                             flags_i,
  output logic                                              valid_o,
  input  logic                                              ready_i,
  output logic [rbst_pkg::NumPairs-1:0][2*COORD_WIDTH+1:0]  far_prod_o,
  output logic [rbst_pkg::NumPairs-1:0][2*COORD_WIDTH+1:0]  near_prod_o,
  output rbst_pkg::axis_flags_t                             flags_o
);

  localparam int unsigned ProdWidth = 2 * COORD_WIDTH + 2;

  logic [rbst_pkg::NumPairs-1:0][ProdWidth-1:0] far_prod_d, near_prod_d;
  logic [rbst_pkg::NumPairs-1:0][ProdWidth-1:0] far_prod_q, near_prod_q;
  rbst_pkg::axis_flags_t                        flags_q;
  logic                                         valid_q;

  for (genvar k = 0; k < rbst_pkg::NumPairs; k++) begin : g_pair
    localparam int unsigned NearAx = rbst_pkg::PairNear[k];
    localparam int unsigned FarAx  = rbst_pkg::PairFar[k];
    logic signed [COORD_WIDTH:0] near_s, far_s, den_near_s, den_far_s;
    logic signed [ProdWidth-1:0] far_prod, near_prod;

    assign near_s     = near_i[NearAx];
    assign far_s      = far_i[FarAx];
    assign den_near_s = {1'b0, den_i[NearAx]};
    assign den_far_s  = {1'b0, den_i[FarAx]};

    // far_j / den_j >= near_i / den_i  <=>  far_j * den_i >= near_i * den_j
    assign far_prod  = far_s * den_near_s;
    assign near_prod = near_s * den_far_s;

    assign far_prod_d[k]  = far_prod;
    assign near_prod_d[k] = near_prod;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      far_prod_q  <= far_prod_d;
      near_prod_q <= near_prod_d;
      flags_q     <= flags_i;
    end
  end

  assign valid_o     = valid_q;
  assign far_prod_o  = far_prod_q;
  assign near_prod_o = near_prod_q;
  assign flags_o     = flags_q;

endmodule

### hdl/rbst_cmp.sv
// Third pipeline stage: pairwise product compares, hit reduction, output register.
// Depends on rbst_pkg.
module rbst_cmp #(
  parameter int unsigned COORD_WIDTH = rbst_pkg::CoordWidthDef
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  output logic                                              ready_o,
  input  logic [rbst_pkg::NumPairs-1:0][2*COORD_WIDTH+1:0]  far_prod_i,
  input  logic [rbst_pkg::NumPairs-1:0][2*COORD_WIDTH+1:0]  near_prod_i,
  input  rbst_pkg::axis_flags_t                             flags_i,
  output logic                                              valid_o,
  input  logic                                              ready_i,
  output logic                                              hit_o
);

  logic [rbst_pkg::NumPairs-1:0] pair_ok;
  logic                          hit_d, hit_q;
  logic                          valid_q;

  for (genvar k = 0; k < rbst_pkg::NumPairs; k++) begin : g_pair
    localparam int unsigned NearAx = rbst_pkg::PairNear[k];
    localparam int unsigned FarAx  = rbst_pkg::PairFar[k];
    // Axes with a zero direction place no bound on t and drop out of the pairs.
    assign pair_ok[k] = flags_i.dir_zero[NearAx] || flags_i.dir_zero[FarAx] ||
                        ($signed(far_prod_i[k]) >= $signed(near_prod_i[k]));
  end

  assign hit_d   = (&flags_i.axis_ok) && (&pair_ok);
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

### test/rbst_checker.sv
`timescale 1ns / 100ps
// Checker for the ray versus box slab test: watches the box, result and configuration
// ports, predicts every hit flag and compares it with the block's result. Uses rbst_pkg.
module rbst_checker (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                s_axis_tvalid,
  input  logic                                                s_axis_tready,
  input  logic [rbst_pkg::NumFields*rbst_pkg::FieldWidth-1:0] s_axis_tdata,
  input  logic                                                m_axis_tvalid,
  input  logic                                                m_axis_tready,
  input  logic [rbst_pkg::OutDataWidth-1:0]                   m_axis_tdata,
  input  logic                                                cfg_we_i,
  input  logic [rbst_pkg::CfgAddrWidth-1:0]                   cfg_addr_i,
  input  logic [rbst_pkg::FieldWidth-1:0]                     cfg_wdata_i,
  output int unsigned                                         error_count_o,
  output int unsigned                                         pending_o,
  output int unsigned                                         boxes_o,
  output int unsigned                                         hits_o,
  output int unsigned                                         misses_o,
  output int unsigned                                         stalls_o
);

  typedef logic [rbst_pkg::NumFields-1:0][rbst_pkg::FieldWidth-1:0] coords_t;
  // Wide enough for any difference of two coordinates.
  typedef logic signed [39:0] wide_t;

  coords_t                          ray_q;
  logic                             hit_expected_q[$];
  logic                             hit_want;
  logic [rbst_pkg::OutDataWidth-1:0] tdata_want;
  int unsigned                      errors, pending, boxes, hits, misses, stalls;

  assign error_count_o = errors;
  assign pending_o     = pending;
  assign boxes_o       = boxes;
  assign hits_o        = hits;
  assign misses_o      = misses;
  assign stalls_o      = stalls;

  // Sign of an_/ad_ - bn_/bd_ for positive denominators, by cross multiplication.
  function automatic int ratio_order(input wide_t an, input wide_t ad,
                                     input wide_t bn, input wide_t bd);
    logic signed [79:0] lhs, rhs;
    lhs = an * bd;
    rhs = bn * ad;
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  function automatic logic slab_hit(input coords_t ray, input coords_t box);
    wide_t org, dir, lo, hi, near_num, far_num, span;
    wide_t entry_num, entry_den, exit_num, exit_den;
    logic  hit_flag, exit_set;
    int    ax;
    hit_flag  = 1'b1;
    exit_set  = 1'b0;
    entry_num = 0;
    entry_den = 1;
    exit_num  = 0;
    exit_den  = 1;
    for (ax = 0; ax < rbst_pkg::NumAxes; ax++) begin
      org = $signed(ray[ax]);
      dir = $signed(ray[ax + rbst_pkg::NumAxes]) - org;
      lo  = $signed(box[ax]);
      hi  = $signed(box[ax + rbst_pkg::NumAxes]);
      if (dir == 0) begin
        // A flat axis limits nothing in t, but the origin has to sit in the slab.
        if (org < lo || org > hi) hit_flag = 1'b0;
      end else begin
        if (dir > 0) begin
          near_num = lo - org;
          far_num  = hi - org;
          span     = dir;
        end else begin
          near_num = org - hi;
          far_num  = org - lo;
          span     = -dir;
        end
        if (ratio_order(near_num, span, entry_num, entry_den) > 0) begin
          entry_num = near_num;
          entry_den = span;
        end
        if (!exit_set || ratio_order(far_num, span, exit_num, exit_den) < 0) begin
          exit_num = far_num;
          exit_den = span;
          exit_set = 1'b1;
        end
      end
    end
    if (exit_set && ratio_order(exit_num, exit_den, entry_num, entry_den) < 0)
      hit_flag = 1'b0;
    return hit_flag;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q <= '0;
      hit_expected_q.delete();
      errors  = 0;
      pending = 0;
      boxes   = 0;
      hits    = 0;
      misses  = 0;
      stalls  = 0;
    end else begin
      if (cfg_we_i && cfg_addr_i <= rbst_pkg::RegThroughZ)
        ray_q[cfg_addr_i] <= cfg_wdata_i;
      if (s_axis_tvalid && !s_axis_tready) stalls++;
      if (s_axis_tvalid && s_axis_tready) begin
        hit_expected_q.push_back(slab_hit(ray_q, s_axis_tdata));
        boxes++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (hit_expected_q.size() == 0) begin
          $display("%0t ns: result transaction with no box pending, got %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          hit_want   = hit_expected_q.pop_front();
          tdata_want = '0;
          tdata_want[0] = hit_want;
          if (hit_want) hits++;
          else misses++;
          if (m_axis_tdata !== tdata_want) begin
            $display("%0t ns: hit flag mismatch, expected %h, got %h",
                     $time, tdata_want, m_axis_tdata);
            errors++;
          end
        end
      end
      pending = hit_expected_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for ray_box_slab_test: programs ray settings, streams boxes with
// random gaps and output stalls, and reports the verdict. Needs rbst_pkg and rbst_checker.
module tb_top;

  typedef logic [rbst_pkg::NumFields-1:0][rbst_pkg::FieldWidth-1:0] coords_t;

  localparam int CoordMax    = 32'h7fff_ffff;
  localparam int CoordMin    = -CoordMax - 1;
  // Register indexes past the ray registers; the block must ignore writes to them.
  localparam logic [rbst_pkg::CfgAddrWidth-1:0] RegSpareLo = 3'd6;
  localparam logic [rbst_pkg::CfgAddrWidth-1:0] RegSpareHi = 3'd7;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;
  localparam int LimitCycles = 200000;

  logic                              clk, rst_n;
  logic                              box_valid, box_ready;
  coords_t                           box_data;
  logic                              hit_valid, hit_ready;
  logic [rbst_pkg::OutDataWidth-1:0] hit_data;
  logic                              cfg_we;
  logic [rbst_pkg::CfgAddrWidth-1:0] cfg_addr;
  logic [rbst_pkg::FieldWidth-1:0]   cfg_wdata;

  int unsigned errors, pending, boxes, hits, misses, stalls;
  int unsigned cycles, ray_settings;
  coords_t     ray_now;
  int          burst_left, phase;
  bit          hold_request;
  int          hold_left, pattern_age;
  logic [15:0] ready_pattern;

  ray_box_slab_test i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (box_valid),
    .s_axis_tready (box_ready),
    .s_axis_tdata  (box_data),
    .m_axis_tvalid (hit_valid),
    .m_axis_tready (hit_ready),
    .m_axis_tdata  (hit_data),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  // The checker sees the same wires as the block and keeps its own copy of the ray.
  rbst_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (box_valid),
    .s_axis_tready (box_ready),
    .s_axis_tdata  (box_data),
    .m_axis_tvalid (hit_valid),
    .m_axis_tready (hit_ready),
    .m_axis_tdata  (hit_data),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .error_count_o (errors),
    .pending_o     (pending),
    .boxes_o       (boxes),
    .hits_o        (hits),
    .misses_o      (misses),
    .stalls_o      (stalls)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles without draining.", cycles);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side. The ready line follows a 16-bit rotating pattern that is swapped for a
  // new one when its random age runs out; an all-ones pattern gives stretches with no stall.
  // A hold request from the stimulus keeps ready low until the hold counter runs out,
  // long enough for the pipeline to fill and push back on the box port.
  initial begin
    hit_ready     = 1'b0;
    hold_left     = 0;
    pattern_age   = 0;
    ready_pattern = '1;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        hit_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles - 1;
        hit_ready   <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          case ($urandom_range(0, 3))
            0:       ready_pattern = '1;
            1:       ready_pattern = 16'($urandom);
            2:       ready_pattern = 16'h8001;
            default: ready_pattern = ~(16'h0001 << $urandom_range(1, 15));
          endcase
          // Every pattern lets at least one result through per rotation.
          ready_pattern[0] = 1'b1;
          pattern_age = $urandom_range(16, 96);
        end
        pattern_age--;
        hit_ready    <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  function automatic coords_t make_coords(input int lx, input int ly, input int lz,
                                          input int hx, input int hy, input int hz);
    return {hz, hy, hx, lz, ly, lx};
  endfunction

  function automatic logic [rbst_pkg::FieldWidth-1:0] clamp_coord(input longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v[rbst_pkg::FieldWidth-1:0];
  endfunction

  // A box around a point of the ray, taken at t between -1/4 and 5/4 in steps of 1/8.
  // Most boxes share one t on all axes and so sit on the ray; the others are spread
  // off it, which gives a good mix of hits, misses and near misses.
  function automatic coords_t box_near_ray(input coords_t ray);
    coords_t     b;
    longint      org, dir, mag, pt, lo_off, hi_off;
    int          ax, k;
    int unsigned reach;
    bit          same_t;
    same_t = ($urandom_range(0, 9) < 7);
    k = $urandom_range(0, 12);
    k = k - 2;
    for (ax = 0; ax < rbst_pkg::NumAxes; ax++) begin
      if (!same_t) begin
        k = $urandom_range(0, 12);
        k = k - 2;
      end
      org = longint'($signed(ray[ax]));
      dir = longint'($signed(ray[ax + rbst_pkg::NumAxes])) - org;
      pt  = org + dir * k / 8;
      mag = (dir < 0) ? -dir : dir;
      case ($urandom_range(0, 3))
        0:       reach = 0;
        1:       reach = 3;
        2:       reach = 32'((mag == 0) ? 1000
                             : ((mag / 16 > (1 << 30)) ? (1 << 30) : mag / 16));
        default: reach = 32'((mag == 0) ? 1000
                             : ((mag / 2 > (1 << 30)) ? (1 << 30) : mag / 2));
      endcase
      lo_off = longint'($urandom_range(0, reach));
      hi_off = longint'($urandom_range(0, reach));
      b[ax]                     = clamp_coord(pt - lo_off);
      b[ax + rbst_pkg::NumAxes] = clamp_coord(pt + hi_off);
    end
    return b;
  endfunction

  function automatic coords_t next_box(input coords_t ray);
    coords_t b;
    logic [rbst_pkg::FieldWidth-1:0] tmp;
    int ax, sel, lo, span;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      b = box_near_ray(ray);
    end else if (sel < 65) begin
      // Inverted box: low and high corner swapped on one axis.
      b   = box_near_ray(ray);
      ax  = $urandom_range(0, rbst_pkg::NumAxes - 1);
      tmp = b[ax];
      b[ax] = b[ax + rbst_pkg::NumAxes];
      b[ax + rbst_pkg::NumAxes] = tmp;
    end else if (sel < 75) begin
      for (ax = 0; ax < rbst_pkg::NumAxes; ax++) begin
        lo   = $urandom_range(0, 2400);
        span = $urandom_range(0, 600);
        b[ax]                     = lo - 1200;
        b[ax + rbst_pkg::NumAxes] = lo - 1200 + span;
      end
    end else if (sel < 88) begin
      // Raw random corners; half the time put in order so the box is not inverted.
      for (ax = 0; ax < rbst_pkg::NumFields; ax++) b[ax] = $urandom;
      if ($urandom_range(0, 1)) begin
        for (ax = 0; ax < rbst_pkg::NumAxes; ax++) begin
          if ($signed(b[ax]) > $signed(b[ax + rbst_pkg::NumAxes])) begin
            tmp = b[ax];
            b[ax] = b[ax + rbst_pkg::NumAxes];
            b[ax + rbst_pkg::NumAxes] = tmp;
          end
        end
      end
    end else begin
      // Some axes opened to the full coordinate range, others squeezed to one plane.
      b = box_near_ray(ray);
      for (ax = 0; ax < rbst_pkg::NumAxes; ax++) begin
        case ($urandom_range(0, 2))
          0: ;
          1: begin
            b[ax]                     = CoordMin;
            b[ax + rbst_pkg::NumAxes] = CoordMax;
          end
          default: b[ax + rbst_pkg::NumAxes] = b[ax];
        endcase
      end
    end
    return b;
  endfunction

  // Ray settings: mostly small coordinates where boxes are easy to aim, some full-range
  // and some built from the extreme values; now and then an axis or the whole ray is flat.
  function automatic coords_t pick_ray();
    coords_t r;
    int mode, i, v;
    mode = $urandom_range(0, 9);
    for (i = 0; i < rbst_pkg::NumFields; i++) begin
      if (mode < 5) begin
        v    = $urandom_range(0, 2000);
        r[i] = v - 1000;
      end else if (mode < 8) begin
        r[i] = $urandom;
      end else begin
        case ($urandom_range(0, 4))
          0:       r[i] = CoordMin;
          1:       r[i] = CoordMax;
          2:       r[i] = 0;
          3:       r[i] = -1;
          default: r[i] = 1;
        endcase
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      i = $urandom_range(0, rbst_pkg::NumAxes - 1);
      r[i + rbst_pkg::NumAxes] = r[i];
    end
    if ($urandom_range(0, 11) == 0) begin
      for (i = 0; i < rbst_pkg::NumAxes; i++) r[i + rbst_pkg::NumAxes] = r[i];
    end
    return r;
  endfunction

  // Offers one box. Bursts of random length are separated by random gaps with valid low.
  // Called and returns at a falling edge.
  task automatic push_box(input coords_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        box_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    box_valid <= 1'b1;
    box_data  <= b;
    @(posedge clk);
    while (!box_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every box has its result, then lets the pipeline settle.
  task automatic wait_idle();
    box_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Writes all six ray registers, then one index past them that must be ignored.
  task automatic program_ray(input coords_t r);
    int i;
    for (i = 0; i < rbst_pkg::NumFields; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= rbst_pkg::cfg_reg_e'(i);
      cfg_wdata <= r[i];
      @(negedge clk);
    end
    cfg_addr  <= $urandom_range(0, 1) ? RegSpareLo : RegSpareHi;
    cfg_wdata <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    ray_now = r;
    ray_settings++;
  endtask

  task automatic run_random(input int count);
    int i;
    for (i = 0; i < count; i++) push_box(next_box(ray_now));
  endtask

  initial begin
    rst_n        = 1'b0;
    box_valid    = 1'b0;
    box_data     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    burst_left   = 0;
    hold_request = 1'b0;
    ray_now      = '0;
    ray_settings = 1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset ray: zero length at the origin, so only boxes holding the origin are hit.
    push_box(make_coords(-1, -1, -1, 1, 1, 1));
    push_box(make_coords(0, 0, 0, 0, 0, 0));
    push_box(make_coords(1, 0, 0, 5, 5, 5));
    push_box(make_coords(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    push_box(make_coords(-1, 1, -1, 1, -1, 1));
    wait_idle();

    // Ray along (100, 50) in the z = 0 plane; z has a zero direction.
    program_ray(make_coords(0, 0, 0, 100, 50, 0));
    push_box(make_coords(200, 100, -1, 300, 150, 1));     // ahead of the origin
    push_box(make_coords(-300, -150, -1, -200, -100, 1)); // behind the origin
    push_box(make_coords(-10, -10, -10, 10, 10, 10));     // origin inside
    push_box(make_coords(200, 100, 1, 300, 150, 5));      // flat axis misses the slab
    push_box(make_coords(200, 100, 0, 300, 150, 0));      // flat axis on a thin slab
    push_box(make_coords(100, -50, -1, 200, 50, 1));      // entry equals exit
    push_box(make_coords(101, -50, -1, 200, 50, 1));      // misses by one step
    push_box(make_coords(300, 100, -1, 200, 150, 1));     // inverted on x
    push_box(make_coords(100, 50, 0, 100, 50, 0));        // single point on the ray
    push_box(make_coords(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    wait_idle();

    // Longest possible direction, corner to corner, where the products are widest.
    program_ray(make_coords(CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax));
    push_box(make_coords(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    push_box(make_coords(CoordMax, CoordMin, CoordMax, CoordMax, CoordMin, CoordMax));
    push_box(make_coords(-1, -1, -1, 0, 0, 0));
    push_box(make_coords(-1, 0, -1, -1, 0, -1));          // exact point near the middle
    push_box(make_coords(0, 0, 0, 0, 0, 0));              // just off the ray
    push_box(make_coords(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin));
    run_random(30);
    wait_idle();

    program_ray(make_coords(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin));
    run_random(30);

    // Random ray settings; one of them starts with a long stall on the result side.
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      program_ray(pick_ray());
      if (phase == 2) hold_request = 1'b1;
      run_random(80);
    end
    wait_idle();

    $display("Checked %0d boxes under %0d ray settings: %0d hits, %0d misses.",
             boxes, ray_settings, hits, misses);
    $display("The box port was held off for %0d cycles by stalled results.", stalls);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
